// ===== design/tflc_pkg.sv =====
// Package for the three-level FIFO cache: constants, codes and shared types.
// No dependencies.
package tflc_pkg;

	localparam int L1_DEPTH_DEF = 32;
	localparam int L2_DEPTH_DEF = 128;
	localparam int L3_DEPTH_DEF = 512;
	localparam int TAG_BITS_DEF = 32;

	localparam int COST_W = 10;
	localparam int TOTAL_W = 32;
	localparam int FIELD_TAG_W = 32;
	localparam int CFG_IDX_W = 2;
	// wide enough for any cell index up to 8191 (levels up to 8192 cells deep)
	localparam int CTL_IDX_W = 13;

	localparam logic [CFG_IDX_W-1:0] CFG_L1_COST = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_L2_COST = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_L3_COST = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MEM_COST = 2'd3;

	localparam logic [COST_W-1:0] L1_COST_RST = 10'd4;
	localparam logic [COST_W-1:0] L2_COST_RST = 10'd12;
	localparam logic [COST_W-1:0] L3_COST_RST = 10'd40;
	localparam logic [COST_W-1:0] MEM_COST_RST = 10'd200;

	localparam logic CMD_ACCESS = 1'b0;
	localparam logic CMD_PRELOAD = 1'b1;

	localparam logic [1:0] LVL_L1 = 2'd0;
	localparam logic [1:0] LVL_L2 = 2'd1;
	localparam logic [1:0] LVL_L3 = 2'd2;
	localparam logic [1:0] LVL_MEM = 2'd3;

	localparam logic [1:0] OP_NONE = 2'd0;
	localparam logic [1:0] OP_DROP = 2'd1;
	localparam logic [1:0] OP_ROOM = 2'd2;
	localparam logic [1:0] OP_APPEND = 2'd3;

	typedef struct packed {
		logic                 shift;
		logic [CTL_IDX_W-1:0] shift_from;
		logic                 write;
		logic [CTL_IDX_W-1:0] write_idx;
	} cell_ctl_t;

endpackage

// ===== design/tflc_if.sv =====
// Handshake channels for the three-level FIFO cache: input and result words.
// No dependencies.
interface tflc_in_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [1:0]  level;
	logic [31:0] block_tag;

	modport source(output valid, command, level, block_tag, input ready);
	modport sink(input valid, command, level, block_tag, output ready);
endinterface

interface tflc_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  hit_level;
	logic [9:0]  access_cost;
	logic        evict_valid;
	logic [31:0] evict_tag;
	logic [31:0] total_latency;
	logic [31:0] memory_fetches;

	modport source(output valid, hit_level, access_cost, evict_valid, evict_tag,
		total_latency, memory_fetches, input ready);
	modport sink(input valid, hit_level, access_cost, evict_valid, evict_tag,
		total_latency, memory_fetches, output ready);
endinterface

// ===== design/tflc_cell.sv =====
// A FIFO row cell: holds a tag; takes new_tag on write, next_tag on a shift.
// Depends on tflc_pkg.
module tflc_cell #(
	parameter int TAG_W = 32,
	parameter int INDEX = 0
) (
	input  logic                clk,
	input  tflc_pkg::cell_ctl_t ctl,
	input  logic [TAG_W-1:0]    next_tag,
	input  logic [TAG_W-1:0]    new_tag,
	input  logic [TAG_W-1:0]    key,
	output logic [TAG_W-1:0]    tag,
	output logic                match
);
	import tflc_pkg::*;

	localparam logic [CTL_IDX_W-1:0] MY_IDX = CTL_IDX_W'(INDEX);

	logic [TAG_W-1:0] tag_q;

	always_ff @(posedge clk) begin
		if (ctl.write && ctl.write_idx == MY_IDX) begin
			tag_q <= new_tag;
		end else if (ctl.shift && MY_IDX >= ctl.shift_from) begin
			tag_q <= next_tag;
		end
	end

	assign tag = tag_q;
	assign match = (tag_q == key);

endmodule

// ===== design/tflc_level.sv =====
// One cache level: a row of tag cells in arrival order, oldest in cell 0.
// Depends on tflc_pkg and tflc_cell.
module tflc_level #(
	parameter int DEPTH = 32,
	parameter int TAG_W = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             lookup,
	input  logic [1:0]       op,
	input  logic [TAG_W-1:0] key,
	output logic             hit,
	output logic             full,
	output logic [TAG_W-1:0] oldest
);
	import tflc_pkg::*;

	localparam int FW = $clog2(DEPTH + 1);
	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [FW-1:0] FILL_MAX = FW'(DEPTH);

	logic [FW-1:0]    fill_q;
	logic [FW-1:0]    fill_d;
	logic [IW-1:0]    pos_q;
	logic             hit_q;
	logic [DEPTH-1:0] match;
	logic [DEPTH-1:0] raw_match;
	logic [IW-1:0]    pos_enc;
	cell_ctl_t        ctl;
	logic [TAG_W-1:0] tags [DEPTH];

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic [TAG_W-1:0] nxt;
			if (gi == DEPTH - 1) begin : g_last
				assign nxt = key;
			end else begin : g_mid
				assign nxt = tags[gi+1];
			end
			tflc_cell #(.TAG_W(TAG_W), .INDEX(gi)) u_cell (
				.clk(clk), .ctl(ctl), .next_tag(nxt), .new_tag(key), .key(key),
				.tag(tags[gi]), .match(raw_match[gi])
			);
			assign match[gi] = raw_match[gi] && (FW'(gi) < fill_q);
		end
	endgenerate

	// tags in a level are unique, so OR-ing indexes of matches gives the hit position
	always_comb begin
		pos_enc = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (match[i]) pos_enc = pos_enc | IW'(i);
		end
	end

	assign full = (fill_q == FILL_MAX);
	assign oldest = tags[0];
	assign hit = hit_q;

	always_comb begin
		ctl = '0;
		fill_d = fill_q;
		case (op)
			OP_DROP: begin
				if (hit_q) begin
					ctl.shift = 1'b1;
					ctl.shift_from = CTL_IDX_W'(pos_q);
					fill_d = fill_q - 1'b1;
				end
			end
			OP_ROOM: begin
				if (full) begin
					ctl.shift = 1'b1;
					fill_d = fill_q - 1'b1;
				end
			end
			OP_APPEND: begin
				ctl.write = 1'b1;
				if (full) begin
					ctl.shift = 1'b1;
					ctl.write_idx = CTL_IDX_W'(DEPTH - 1);
				end else begin
					ctl.write_idx = CTL_IDX_W'(fill_q);
					fill_d = fill_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			hit_q <= 1'b0;
		end else begin
			fill_q <= fill_d;
			if (lookup) hit_q <= |match;
		end
	end

	always_ff @(posedge clk) begin
		if (lookup) pos_q <= pos_enc;
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_MAX) else $error("fill count beyond depth");
	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q != $past(fill_q) |-> (fill_q == $past(fill_q) + 1'b1 ||
		fill_q == $past(fill_q) - 1'b1)) else $error("fill moved by more than one");
	a_unique: assert property (@(posedge clk) disable iff (!arst_n)
		lookup |-> $onehot0(match)) else $error("tag held twice in one level");

endmodule

// ===== design/three_level_fifo_cache.sv =====
// Top level of the three-level FIFO cache: control sequencer, cost registers, totals.
// Depends on tflc_pkg, tflc_if and tflc_level.
//
// Usage: words enter on in_ch (command, level, block_tag) and one result word
// leaves on out_ch for each. The user must write the cost registers through cfg_we,
// cfg_index and cfg_data only while the block is idle; the block does not enforce it.
// Each item is handled on its own: accept in idle, parallel tag compare in
// every cell of all three levels, the shift and append of the rows, then the
// load of the output register. A new item is taken only once the last one
// is in the output register, set by the compare-then-update sequence over the
// cell rows.
// in_ch.ready is high only between items. The result sits in an output
// register; when out_ch stalls the next item may already be accepted and
// processed, and it waits for the register to free before it is loaded.
// Reset empties all levels (fill counts cleared), zeroes both totals and
// restores the default costs. No clearing pass is needed.
module three_level_fifo_cache #(
	parameter int L1_ENTRIES = tflc_pkg::L1_DEPTH_DEF,
	parameter int L2_ENTRIES = tflc_pkg::L2_DEPTH_DEF,
	parameter int L3_ENTRIES = tflc_pkg::L3_DEPTH_DEF,
	parameter int TAG_BITS = tflc_pkg::TAG_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	tflc_in_if.sink                           in_ch,
	tflc_out_if.source                        out_ch,
	input  logic                              cfg_we,
	input  logic [tflc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tflc_pkg::COST_W-1:0]       cfg_data
);
	import tflc_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOOK = 2'd1;
	localparam logic [1:0] ST_UPD = 2'd2;
	localparam logic [1:0] ST_PUSH = 2'd3;

	logic [1:0] state_q;
	logic [COST_W-1:0] l1_cost_q, l2_cost_q, l3_cost_q, mem_cost_q;
	logic              cmd_q;
	logic [1:0]        lvl_q;
	logic [TAG_BITS-1:0] key_q;
	logic [TOTAL_W-1:0] lat_q, fetch_q;

	logic [1:0]        res_hit_q;
	logic [COST_W-1:0] res_cost_q;
	logic              res_ev_q;
	logic [FIELD_TAG_W-1:0] res_tag_q;

	logic              out_valid_q;
	logic [1:0]        out_hit_q;
	logic [COST_W-1:0] out_cost_q;
	logic              out_ev_q;
	logic [FIELD_TAG_W-1:0] out_tag_q;
	logic [TOTAL_W-1:0] out_lat_q, out_fetch_q;

	logic lookup;
	logic [1:0] op1, op2, op3;
	logic h1, h2, h3, f1, f2, f3;
	logic [TAG_BITS-1:0] old1, old2, old3;

	logic [1:0]        hit_d;
	logic [COST_W-1:0] cost_d;
	logic              ev_d;
	logic [TAG_BITS-1:0] evtag_d;
	logic              fetch_inc;
	logic [TOTAL_W:0]  lat_sum;

	assign lookup = (state_q == ST_LOOK);

	tflc_level #(.DEPTH(L1_ENTRIES), .TAG_W(TAG_BITS)) u_l1 (
		.clk(clk), .arst_n(arst_n), .lookup(lookup), .op(op1), .key(key_q),
		.hit(h1), .full(f1), .oldest(old1));
	tflc_level #(.DEPTH(L2_ENTRIES), .TAG_W(TAG_BITS)) u_l2 (
		.clk(clk), .arst_n(arst_n), .lookup(lookup), .op(op2), .key(key_q),
		.hit(h2), .full(f2), .oldest(old2));
	tflc_level #(.DEPTH(L3_ENTRIES), .TAG_W(TAG_BITS)) u_l3 (
		.clk(clk), .arst_n(arst_n), .lookup(lookup), .op(op3), .key(key_q),
		.hit(h3), .full(f3), .oldest(old3));

	always_comb begin
		op1 = OP_NONE;
		op2 = OP_NONE;
		op3 = OP_NONE;
		hit_d = LVL_L1;
		cost_d = '0;
		ev_d = 1'b0;
		evtag_d = '0;
		fetch_inc = 1'b0;
		if (state_q == ST_UPD) begin
			if (cmd_q == CMD_PRELOAD) begin
				case (lvl_q)
					LVL_L1: if (!h1) begin
						op1 = OP_APPEND;
						ev_d = f1;
						evtag_d = old1;
					end
					LVL_L2: if (!h2) begin
						op2 = OP_APPEND;
						ev_d = f2;
						evtag_d = old2;
					end
					LVL_L3: if (!h3) begin
						op3 = OP_APPEND;
						ev_d = f3;
						evtag_d = old3;
					end
					default: begin
					end
				endcase
			end else if (h1) begin
				hit_d = LVL_L1;
				cost_d = l1_cost_q;
			end else if (h2) begin
				hit_d = LVL_L2;
				cost_d = l2_cost_q;
			end else begin
				if (h3) begin
					hit_d = LVL_L3;
					cost_d = l3_cost_q;
					op3 = OP_DROP;
				end else begin
					hit_d = LVL_MEM;
					cost_d = mem_cost_q;
					op3 = OP_ROOM;
					fetch_inc = 1'b1;
				end
				op2 = OP_ROOM;
				op1 = OP_APPEND;
				ev_d = f1;
				evtag_d = old1;
			end
		end
	end

	assign lat_sum = {1'b0, lat_q} + (TOTAL_W+1)'(cost_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			l1_cost_q <= L1_COST_RST;
			l2_cost_q <= L2_COST_RST;
			l3_cost_q <= L3_COST_RST;
			mem_cost_q <= MEM_COST_RST;
			lat_q <= '0;
			fetch_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_L1_COST: l1_cost_q <= cfg_data;
					CFG_L2_COST: l2_cost_q <= cfg_data;
					CFG_L3_COST: l3_cost_q <= cfg_data;
					CFG_MEM_COST: mem_cost_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (state_q == ST_PUSH && (!out_valid_q || out_ch.ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: if (in_ch.valid) state_q <= ST_LOOK;
				ST_LOOK: state_q <= ST_UPD;
				ST_UPD: begin
					state_q <= ST_PUSH;
					lat_q <= lat_sum[TOTAL_W] ? '1 : lat_sum[TOTAL_W-1:0];
					if (fetch_inc && fetch_q != '1) fetch_q <= fetch_q + 1'b1;
				end
				ST_PUSH: if (!out_valid_q || out_ch.ready) begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_ch.valid) begin
			cmd_q <= in_ch.command;
			lvl_q <= in_ch.level;
			key_q <= TAG_BITS'(in_ch.block_tag);
		end
		if (state_q == ST_UPD) begin
			res_hit_q <= hit_d;
			res_cost_q <= cost_d;
			res_ev_q <= ev_d;
			res_tag_q <= ev_d ? FIELD_TAG_W'(evtag_d) : '0;
		end
		if (state_q == ST_PUSH && (!out_valid_q || out_ch.ready)) begin
			out_hit_q <= res_hit_q;
			out_cost_q <= res_cost_q;
			out_ev_q <= res_ev_q;
			out_tag_q <= res_tag_q;
			out_lat_q <= lat_q;
			out_fetch_q <= fetch_q;
		end
	end

	assign in_ch.ready = (state_q == ST_IDLE);
	assign out_ch.valid = out_valid_q;
	assign out_ch.hit_level = out_hit_q;
	assign out_ch.access_cost = out_cost_q;
	assign out_ch.evict_valid = out_ev_q;
	assign out_ch.evict_tag = out_tag_q;
	assign out_ch.total_latency = out_lat_q;
	assign out_ch.memory_fetches = out_fetch_q;

	a_load_from_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_PUSH) else $error("result without item");
	a_fetch_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		fetch_q != $past(fetch_q) |-> $past(state_q) == ST_UPD && $past(fetch_inc))
		else $error("fetch count moved without a miss");
	a_lat_mono: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |=> lat_q >= $past(lat_q)) else $error("latency total fell");

endmodule

// ===== tb/sv/three_level_fifo_cache_test.sv =====
// Testbench for three_level_fifo_cache: directed and random access/preload words,
// checked against an in-bench FIFO hierarchy predictor. Needs tflc_pkg, tflc_if, DUT.
`timescale 1ns / 1ps

module three_level_fifo_cache_test;
	import tflc_pkg::*;

	localparam int L1_CAP = 32;
	localparam int L2_CAP = 128;
	localparam int L3_CAP = 512;
	localparam int CYCLE_LIMIT = 400000;
	localparam int POOL_N = 600;

	typedef struct {
		bit        cmd;
		bit [1:0]  lvl;
		bit [31:0] tag;
	} word_t;

	typedef struct {
		bit [1:0]  hit_level;
		bit [9:0]  access_cost;
		bit        evict_valid;
		bit [31:0] evict_tag;
		bit [31:0] total_latency;
		bit [31:0] memory_fetches;
	} res_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COST_W-1:0] cfg_data;

	tflc_in_if in_ch();
	tflc_out_if out_ch();

	three_level_fifo_cache u_top (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor state
	bit [31:0] l1_tags[$];
	bit [31:0] l2_tags[$];
	bit [31:0] l3_tags[$];
	bit [31:0] lat_sum;
	bit [31:0] fetch_cnt;
	bit [9:0] cost_reg[4];

	word_t pending_words[$];
	res_t expected_results[$];
	word_t cur_word;
	bit [31:0] tag_pool[POOL_N];
	int pool_size;

	bit in_taken;
	bit no_idle;
	bit hold_out;
	int errors;
	int n_accepted;
	int n_checked;
	int n_l3_hits;
	int n_misses;
	int n_evicts;
	int cycles;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int find_tag(ref bit [31:0] q[$], input bit [31:0] t);
		foreach (q[i])
			if (q[i] == t) return i;
		return -1;
	endfunction

	// removes and returns the oldest tag of a level
	function automatic bit [31:0] take_oldest(ref bit [31:0] q[$]);
		bit [31:0] t;
		t = q[0];
		q.delete(0);
		return t;
	endfunction

	function automatic bit [31:0] sat_add(bit [31:0] a, bit [31:0] b);
		bit [32:0] s;
		s = a + b;
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic res_t lookup_cache(word_t w);
		res_t r;
		int p;
		r = '{default: 0};
		if (w.cmd == CMD_PRELOAD) begin
			case (w.lvl)
				LVL_L1: if (find_tag(l1_tags, w.tag) < 0) begin
					if (l1_tags.size() >= L1_CAP) begin
						r.evict_valid = 1;
						r.evict_tag = take_oldest(l1_tags);
					end
					l1_tags = {l1_tags, w.tag};
				end
				LVL_L2: if (find_tag(l2_tags, w.tag) < 0) begin
					if (l2_tags.size() >= L2_CAP) begin
						r.evict_valid = 1;
						r.evict_tag = take_oldest(l2_tags);
					end
					l2_tags = {l2_tags, w.tag};
				end
				LVL_L3: if (find_tag(l3_tags, w.tag) < 0) begin
					if (l3_tags.size() >= L3_CAP) begin
						r.evict_valid = 1;
						r.evict_tag = take_oldest(l3_tags);
					end
					l3_tags = {l3_tags, w.tag};
				end
				default: ;
			endcase
		end else if (find_tag(l1_tags, w.tag) >= 0) begin
			r.hit_level = LVL_L1;
			r.access_cost = cost_reg[CFG_L1_COST];
		end else if (find_tag(l2_tags, w.tag) >= 0) begin
			r.hit_level = LVL_L2;
			r.access_cost = cost_reg[CFG_L2_COST];
		end else begin
			p = find_tag(l3_tags, w.tag);
			if (p >= 0) begin
				r.hit_level = LVL_L3;
				r.access_cost = cost_reg[CFG_L3_COST];
				l3_tags.delete(p);
			end else begin
				r.hit_level = LVL_MEM;
				r.access_cost = cost_reg[CFG_MEM_COST];
				fetch_cnt = sat_add(fetch_cnt, 1);
				if (l3_tags.size() >= L3_CAP) void'(take_oldest(l3_tags));
			end
			// L2 and L3 drops are silent
			if (l2_tags.size() >= L2_CAP) void'(take_oldest(l2_tags));
			if (l1_tags.size() >= L1_CAP) begin
				r.evict_valid = 1;
				r.evict_tag = take_oldest(l1_tags);
			end
			l1_tags = {l1_tags, w.tag};
		end
		lat_sum = sat_add(lat_sum, 32'(r.access_cost));
		r.total_latency = lat_sum;
		r.memory_fetches = fetch_cnt;
		return r;
	endfunction

	task automatic report(string field, bit [31:0] got, bit [31:0] want);
		errors++;
		$display("ERROR word %0d: %s got %0h want %0h", n_checked, field, got, want);
	endtask

	// driver: inputs change on the falling edge
	always @(negedge clk) begin
		if (arst_n && !(in_ch.valid && !in_taken)) begin
			if (pending_words.size() > 0 && (no_idle || $urandom_range(0, 99) >= 32)) begin
				cur_word = pending_words[0];
				pending_words.delete(0);
				in_ch.command <= cur_word.cmd;
				in_ch.level <= cur_word.lvl;
				in_ch.block_tag <= cur_word.tag;
				in_ch.valid <= 1'b1;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk)
		if (arst_n)
			out_ch.ready <= !hold_out && (no_idle || $urandom_range(0, 99) >= 32);

	// monitor: sample on the rising edge
	always @(posedge clk) begin
		res_t e;
		if (arst_n) begin
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("three_level_fifo_cache: mismatch");
				$finish;
			end
			in_taken <= in_ch.valid && in_ch.ready;
			if (in_ch.valid && in_ch.ready) begin
				expected_results.push_back(lookup_cache(cur_word));
				n_accepted++;
			end
			if (out_ch.valid && out_ch.ready) begin
				n_checked++;
				if (expected_results.size() == 0) begin
					report("unexpected word", '0, '0);
				end else begin
					e = expected_results.pop_front();
					if (e.hit_level == LVL_L3) n_l3_hits++;
					if (e.hit_level == LVL_MEM) n_misses++;
					if (e.evict_valid) n_evicts++;
					if (out_ch.hit_level !== e.hit_level)
						report("hit_level", 32'(out_ch.hit_level), 32'(e.hit_level));
					if (out_ch.access_cost !== e.access_cost)
						report("access_cost", 32'(out_ch.access_cost), 32'(e.access_cost));
					if (out_ch.evict_valid !== e.evict_valid)
						report("evict_valid", 32'(out_ch.evict_valid), 32'(e.evict_valid));
					if (out_ch.evict_tag !== e.evict_tag)
						report("evict_tag", out_ch.evict_tag, e.evict_tag);
					if (out_ch.total_latency !== e.total_latency)
						report("total_latency", out_ch.total_latency, e.total_latency);
					if (out_ch.memory_fetches !== e.memory_fetches)
						report("memory_fetches", out_ch.memory_fetches, e.memory_fetches);
				end
			end
		end
	end

	// long receiver stall so the block backs up and stalls its input
	initial begin
		hold_out = 0;
		wait (n_accepted >= 150);
		@(posedge clk);
		hold_out = 1;
		repeat (400) @(posedge clk);
		hold_out = 0;
	end

	function automatic bit [31:0] pick_tag();
		if ($urandom_range(0, 9) == 0) return $urandom;
		return tag_pool[$urandom_range(0, pool_size - 1)];
	endfunction

	task automatic push_word(bit cmd, bit [1:0] lvl, bit [31:0] tag);
		word_t w;
		w.cmd = cmd;
		w.lvl = lvl;
		w.tag = tag;
		pending_words = {pending_words, w};
	endtask

	task automatic push_random(int n, int psz);
		pool_size = psz;
		repeat (n) begin
			if ($urandom_range(0, 99) < 60) push_word(CMD_ACCESS, 2'($urandom), pick_tag());
			else push_word(CMD_PRELOAD, 2'($urandom_range(0, 3)), pick_tag());
		end
	endtask

	task automatic drain();
		@(negedge clk);
		while (pending_words.size() != 0 || in_ch.valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, bit [9:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		cost_reg[idx] = val;
	endtask

	task automatic write_all(bit [9:0] a, bit [9:0] b, bit [9:0] c, bit [9:0] d);
		write_reg(CFG_L1_COST, a);
		write_reg(CFG_L2_COST, b);
		write_reg(CFG_L3_COST, c);
		write_reg(CFG_MEM_COST, d);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.command = CMD_ACCESS;
		in_ch.level = LVL_L1;
		in_ch.block_tag = '0;
		out_ch.ready = 1'b0;
		in_taken = 0;
		no_idle = 0;
		errors = 0;
		cost_reg[CFG_L1_COST] = L1_COST_RST;
		cost_reg[CFG_L2_COST] = L2_COST_RST;
		cost_reg[CFG_L3_COST] = L3_COST_RST;
		cost_reg[CFG_MEM_COST] = MEM_COST_RST;
		foreach (tag_pool[i]) tag_pool[i] = $urandom;
		tag_pool[0] = 32'h0;
		tag_pool[1] = 32'hFFFF_FFFF;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: default costs first
		push_word(CMD_ACCESS, LVL_L1, 32'h0);
		push_word(CMD_ACCESS, LVL_MEM, 32'hFFFF_FFFF);
		push_word(CMD_ACCESS, LVL_L1, 32'h0);
		push_word(CMD_PRELOAD, LVL_L2, 32'h5);
		push_word(CMD_ACCESS, LVL_L1, 32'h5);
		push_word(CMD_PRELOAD, LVL_L3, 32'h7);
		push_word(CMD_ACCESS, LVL_L2, 32'h7);
		push_word(CMD_ACCESS, LVL_L1, 32'h7);
		push_word(CMD_PRELOAD, LVL_MEM, 32'h9); // ignored target
		push_word(CMD_ACCESS, LVL_L1, 32'h9);
		push_word(CMD_PRELOAD, LVL_L1, 32'h9); // already present
		push_word(CMD_PRELOAD, LVL_L2, 32'h9); // same tag in two levels
		push_word(CMD_PRELOAD, LVL_L3, 32'hFFFF_FFFF);
		push_word(CMD_ACCESS, LVL_L1, 32'hFFFF_FFFF);
		push_word(CMD_PRELOAD, LVL_L3, 32'hA5A5_5A5A);
		push_word(CMD_PRELOAD, LVL_L3, 32'hA5A5_5A5A);
		push_word(CMD_ACCESS, LVL_L1, 32'hA5A5_5A5A);
		push_random(40, 40);
		drain();

		write_all(10'($urandom), 10'($urandom), 10'($urandom), 10'($urandom));
		push_random(30, 200);
		drain();

		// fill L3 past capacity, then work it with no idling on either side
		write_all(10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF);
		no_idle = 1;
		for (int i = 0; i < 520; i++) push_word(CMD_PRELOAD, LVL_L3, tag_pool[i % POOL_N]);
		push_random(30, POOL_N);
		drain();

		no_idle = 0;
		write_all(10'h0, 10'h0, 10'h0, 10'h0);
		push_random(10, 150);
		drain();

		write_all(L1_COST_RST, 10'h3FF, 10'h1, 10'h3FF);
		push_random(10, 60);
		drain();
		repeat (20) @(posedge clk);

		$display("%0d words accepted, %0d results checked: %0d L3 hits, %0d misses, %0d evictions",
			n_accepted, n_checked, n_l3_hits, n_misses, n_evicts);
		$display("cost settings covered reset, random, all zero and all max");
		if (errors == 0) begin
			$display("three_level_fifo_cache: match");
		end else begin
			$display("three_level_fifo_cache: mismatch");
		end
		$finish;
	end

endmodule

// ===== files.f =====
design/tflc_pkg.sv
design/tflc_if.sv
design/tflc_cell.sv
design/tflc_level.sv
design/three_level_fifo_cache.sv
tb/sv/three_level_fifo_cache_test.sv
